// ===== src/sird_pkg.sv =====
package sird_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_CELLS = DATA_W;
  localparam int MAX_RADIX = 16;
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int ALPHA_W   = 64;
  localparam int IDX_W     = $clog2(NUM_CELLS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX_LENGTH  = 2'd0,
    REG_ALPHABET_LOW  = 2'd1,
    REG_ALPHABET_HIGH = 2'd2
  } cfg_reg_t;

  // One bit of a quotient stream passed from cell to cell, MSB first.
  typedef struct packed {
    logic dat;
    logic vld;
  } sird_link_t;

  // Pick digit character k out of the packed 16-character alphabet.
  function automatic logic [CHAR_W-1:0] alpha_char(
    input logic [2*ALPHA_W-1:0] alphabet,
    input logic [DIGIT_W-1:0]   k
  );
    return alphabet[k*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== src/sird_cell.sv =====
module sird_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic [sird_pkg::RADIX_W-1:0] radix,
  input  sird_pkg::sird_link_t         in_link,
  output sird_pkg::sird_link_t         out_link,
  output logic [sird_pkg::DIGIT_W-1:0] digit,
  output logic                         seen
);
  import sird_pkg::*;

  logic [DIGIT_W-1:0] rem_r, rem_nxt;
  logic               seen_r, seen_nxt;
  sird_link_t         link_r, link_nxt;
  logic [RADIX_W-1:0] trial;
  logic               ge;

  // One restoring division step: bring in the next dividend bit, subtract the radix if it fits.
  assign trial = {rem_r, in_link.dat};
  assign ge    = (trial >= radix);

  always_comb begin
    rem_nxt  = rem_r;
    seen_nxt = seen_r;
    link_nxt = '{dat: 1'b0, vld: 1'b0};
    if (clear) begin
      rem_nxt  = '0;
      seen_nxt = 1'b0;
    end else if (in_link.vld) begin
      rem_nxt  = ge ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
      seen_nxt = seen_r | in_link.dat;
      link_nxt = '{dat: ge, vld: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      link_r <= '{dat: 1'b0, vld: 1'b0};
    end else begin
      seen_r <= seen_nxt;
      link_r <= link_nxt;
    end
    rem_r <= rem_nxt;
  end

  assign out_link = link_r;
  assign digit    = rem_r;
  assign seen     = seen_r;

endmodule

// ===== src/sird_alpha_check.sv =====
module sird_alpha_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sird_pkg::RADIX_W-1:0]     radix,
  input  logic [2*sird_pkg::ALPHA_W-1:0]   alphabet,
  output logic                             ok
);
  import sird_pkg::*;

  logic ok_r, ok_nxt;

  always_comb begin
    logic               bad;
    logic [CHAR_W-1:0]  ci;
    logic [CHAR_W-1:0]  cj;
    bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      ci = alpha_char(alphabet, DIGIT_W'(i));
      if ((RADIX_W'(i) < radix) && ((ci == CH_PLUS) || (ci == CH_MINUS))) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < MAX_RADIX; j++) begin
        cj = alpha_char(alphabet, DIGIT_W'(j));
        if ((RADIX_W'(j) < radix) && (ci == cj)) begin
          bad = 1'b1;
        end
      end
    end
    ok_nxt = !bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= ok_nxt;
    end
  end

  assign ok = ok_r;

endmodule

// ===== src/signed_integer_to_radix_digits.sv =====
// Signed 32-bit integer to text in a programmable radix of 2 to 16. Program radix_length
// (index 0) and the digit characters in alphabet_low (index 1, characters 0-7) and
// alphabet_high (index 2, characters 8-15), one byte per character, lowest byte first;
// write them only while the block is idle. Each value then yields a '-' if negative
// followed by its digits, most significant first, one character per item with tlast on
// the final digit; zero gives the single character 0 of the alphabet and the most
// negative value is printed from its magnitude 2147483648. An alphabet shorter than
// two, longer than sixteen, holding '+' or '-', or repeating a character makes the block
// swallow every value without output. For each value the block checks the alphabet, runs
// the 32 magnitude bits MSB first through the row of 32 division cells, each quotient bit
// rippling on to the cell of the next digit, locates the leading digit, then emits one
// character per cycle while the sink keeps tready high. A new value is taken once the
// last character has been loaded into the output register.
module signed_integer_to_radix_digits (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [31:0] number (signed)
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [sird_pkg::DATA_W-1:0]  in_tdata,
  // out_tdata: [7:0] character; out_tlast carries final_char
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sird_pkg::CHAR_W-1:0]         out_tdata,
  output logic                                out_tlast,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sird_pkg::ALPHA_W-1:0]        cfg_data
);
  import sird_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CONV,
    S_FIND,
    S_SIGN,
    S_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(2 * NUM_CELLS - 2);

  state_t              state_r;
  logic [RADIX_W-1:0]  radix_length_r;
  logic [ALPHA_W-1:0]  alphabet_low_r;
  logic [ALPHA_W-1:0]  alphabet_high_r;
  logic [DATA_W-1:0]   mag_r;
  logic                neg_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [IDX_W-1:0]    idx_r;
  logic                out_tvalid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  logic                alpha_ok;
  logic                out_free;
  logic                out_load;
  logic [IDX_W-1:0]    top_idx;
  logic [2*ALPHA_W-1:0] alphabet;
  sird_link_t          head_link;
  sird_link_t          link [NUM_CELLS];
  logic [DIGIT_W-1:0]  digit [NUM_CELLS];
  logic [NUM_CELLS-1:0] seen;

  assign alphabet  = {alphabet_high_r, alphabet_low_r};
  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  // A character goes into the output register in this cycle.
  assign out_load  = ((state_r == S_SIGN) || (state_r == S_EMIT)) && out_free;

  // Configuration registers: unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_length_r  <= '0;
      alphabet_low_r  <= '0;
      alphabet_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIX_LENGTH:  radix_length_r  <= cfg_data[RADIX_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low_r  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sird_alpha_check u_alpha_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .radix    (radix_length_r),
    .alphabet (alphabet),
    .ok       (alpha_ok)
  );

  // Feed the 32 magnitude bits into the first cell, MSB first.
  assign head_link = '{dat: mag_r[DATA_W-1], vld: (state_r == S_CONV) && !cnt_r[CNT_W-1]};

  // Cell k divides the quotient stream of cell k-1 by the radix; its remainder is digit k.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sird_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (state_r == S_CHECK),
      .radix    (radix_length_r),
      .in_link  ((k == 0) ? head_link : link[(k == 0) ? 0 : k - 1]),
      .out_link (link[k]),
      .digit    (digit[k]),
      .seen     (seen[k])
    );
  end

  // A cell that saw a 1 bit has a nonzero dividend, so its digit belongs to the text.
  always_comb begin
    top_idx = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (seen[k]) begin
        top_idx = IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            neg_r   <= in_tdata[DATA_W-1];
            mag_r   <= in_tdata[DATA_W-1] ? (DATA_W'(0) - DATA_W'(in_tdata))
                                          : DATA_W'(in_tdata);
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Drop the value outright when the alphabet is unusable.
          cnt_r   <= '0;
          state_r <= alpha_ok ? S_CONV : S_IDLE;
        end
        S_CONV: begin
          mag_r <= {mag_r[DATA_W-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CONV_LAST) begin
            state_r <= S_FIND;
          end
        end
        S_FIND: begin
          idx_r   <= top_idx;
          state_r <= neg_r ? S_SIGN : S_EMIT;
        end
        S_SIGN: begin
          if (out_free) begin
            out_char_r   <= CH_MINUS;
            out_last_r   <= 1'b0;
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_char_r   <= alpha_char(alphabet, digit[idx_r]);
            out_last_r   <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - IDX_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/signed_integer_to_radix_digits_test.sv =====
`timescale 1ns / 100ps

// Signed 32-bit values go in and come back as text in the programmed radix.
// A directed table covers reset state, field extremes and each invalid alphabet.
// Random alphabets and values follow, with stalls on both sides of the block.
// Every character is compared with typed text or with a local model of the conversion.
module signed_integer_to_radix_digits_test;

  localparam int IDLE_GAP         = 128;  // beyond the worst case of one value
  localparam int SINK_HOLD_CYCLES = 600;
  localparam int RANDOM_VALUES    = 227;

  // Index 3 decodes to no register and must be ignored.
  localparam logic [sird_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic [sird_pkg::CHAR_W-1:0] character;
    logic                        final_char;
  } char_item_t;

  typedef enum {ROW_VALUE, ROW_WRITE, ROW_ALPHABET} row_kind_t;
  typedef enum {ALPHA_GOOD, ALPHA_BAD_LENGTH, ALPHA_SIGN, ALPHA_REPEAT} alpha_flavour_t;

  // ROW_ALPHABET uses text as the digit string. ROW_VALUE uses it as the expected text
  // when typed is set.
  typedef struct {
    row_kind_t                            kind;
    logic [sird_pkg::CFG_IDX_W-1:0]       index;
    logic [sird_pkg::ALPHA_W-1:0]         data;
    logic signed [sird_pkg::DATA_W-1:0]   number;
    bit                                   typed;
    string                                text;
  } stim_row_t;

  logic                                clk        = 1'b0;
  logic                                rst_n      = 1'b0;
  logic                                in_tvalid  = 1'b0;
  logic                                in_tready;
  logic signed [sird_pkg::DATA_W-1:0]  in_tdata   = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [sird_pkg::CHAR_W-1:0]         out_tdata;
  logic                                out_tlast;
  logic                                cfg_valid  = 1'b0;
  logic                                cfg_ready;
  logic [sird_pkg::CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [sird_pkg::ALPHA_W-1:0]        cfg_data   = '0;

  // Local copy of the registers; the alphabet is held as one 16-character word.
  logic [sird_pkg::RADIX_W-1:0]        radix_len  = '0;
  logic [2*sird_pkg::ALPHA_W-1:0]      alphabet   = '0;

  char_item_t pending_chars[$];
  char_item_t head_char;
  int         error_count   = 0;
  bit         values_sent   = 1'b0;
  bit         steady_mode   = 1'b0;
  bit         sink_hold_req = 1'b0;

  signed_integer_to_radix_digits DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Conversion model
  // ---------------------------------------------------------------------------

  function automatic bit alphabet_usable();
    logic [sird_pkg::CHAR_W-1:0] c;
    if (radix_len < 2 || radix_len > sird_pkg::MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix_len; i++) begin
      c = alphabet[i*8 +: 8];
      if (c == sird_pkg::CH_PLUS || c == sird_pkg::CH_MINUS) return 1'b0;
      for (int j = i + 1; j < radix_len; j++)
        if (alphabet[j*8 +: 8] == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters that one value turns into. Take the magnitude as unsigned,
  // so that the most negative value converts cleanly.
  function automatic void predict_text(input logic [sird_pkg::DATA_W-1:0] raw);
    logic [31:0] mag;
    logic [31:0] base;
    logic [3:0]  digits[$];
    if (!alphabet_usable()) return;
    mag  = raw[31] ? (~raw + 32'd1) : raw;
    base = {27'd0, radix_len};
    do begin
      digits.push_front(4'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    if (raw[31]) pending_chars.push_back('{sird_pkg::CH_MINUS, 1'b0});
    foreach (digits[k])
      pending_chars.push_back('{alphabet[digits[k]*8 +: 8], k == digits.size() - 1});
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int roll;
    if (steady_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  // Wait for every queued character to arrive. Advance the clock even if nothing is pending.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  // Offer one value. Hold it until accepted, then queue its expected characters:
  // the typed text where given, the model otherwise.
  task automatic send_number(input logic signed [31:0] number, input bit typed,
                             input string text);
    int gap;
    gap = pick_gap();
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= number;
    do @(posedge clk); while (!in_tready);
    values_sent = 1'b1;
    if (typed) begin
      for (int i = 0; i < text.len(); i++)
        pending_chars.push_back('{text[i], i == text.len() - 1});
    end else begin
      predict_text(number);
    end
  endtask

  // Write only while idle. With an invalid alphabet a value leaves nothing to wait on,
  // so allow the block its full latency after the last character.
  task automatic write_register(input logic [sird_pkg::CFG_IDX_W-1:0] index,
                                input logic [sird_pkg::ALPHA_W-1:0] data);
    if (values_sent) begin
      drain_results();
      repeat (IDLE_GAP) @(posedge clk);
      values_sent = 1'b0;
    end
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      sird_pkg::REG_RADIX_LENGTH:  radix_len = data[sird_pkg::RADIX_W-1:0];
      sird_pkg::REG_ALPHABET_LOW:  alphabet[sird_pkg::ALPHA_W-1:0] = data;
      sird_pkg::REG_ALPHABET_HIGH: alphabet[2*sird_pkg::ALPHA_W-1:sird_pkg::ALPHA_W] = data;
      default: ;
    endcase
  endtask

  function automatic stim_row_t value_row(input logic signed [31:0] number, input bit typed,
                                          input string text);
    stim_row_t row;
    row.kind   = ROW_VALUE;
    row.index  = '0;
    row.data   = '0;
    row.number = number;
    row.typed  = typed;
    row.text   = text;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [sird_pkg::CFG_IDX_W-1:0] index,
                                          input logic [sird_pkg::ALPHA_W-1:0] data);
    stim_row_t row;
    row = value_row('0, 1'b0, "");
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic stim_row_t alphabet_row(input string digits);
    stim_row_t row;
    row = value_row('0, 1'b0, digits);
    row.kind = ROW_ALPHABET;
    return row;
  endfunction

  task automatic run_directed();
    stim_row_t                      rows[$];
    logic [2*sird_pkg::ALPHA_W-1:0] word;
    // Reset leaves a radix of zero, so values vanish.
    rows.push_back(value_row(0, 1'b1, ""));
    rows.push_back(value_row(32'sh8000_0000, 1'b1, ""));
    // Decimal: zero, both extremes, minus one.
    rows.push_back(alphabet_row("0123456789"));
    rows.push_back(value_row(0, 1'b1, "0"));
    rows.push_back(value_row(32'sh7FFF_FFFF, 1'b1, "2147483647"));
    rows.push_back(value_row(32'sh8000_0000, 1'b1, "-2147483648"));
    rows.push_back(value_row(-1, 1'b1, "-1"));
    rows.push_back(value_row(1234, 1'b1, "1234"));
    // Binary: the most negative value gives the longest text.
    rows.push_back(alphabet_row("01"));
    rows.push_back(value_row(32'sh8000_0000, 1'b0, ""));
    rows.push_back(value_row(32'sh7FFF_FFFF, 1'b0, ""));
    rows.push_back(value_row(-1, 1'b1, "-1"));
    rows.push_back(value_row(2, 1'b1, "10"));
    // Full sixteen characters, reaching into the high word.
    rows.push_back(alphabet_row("0123456789ABCDEF"));
    rows.push_back(value_row(32'sh8000_0000, 1'b1, "-80000000"));
    rows.push_back(value_row(32'sh7FFF_FFFF, 1'b1, "7FFFFFFF"));
    rows.push_back(value_row(16, 1'b1, "10"));
    rows.push_back(value_row(-255, 1'b1, "-FF"));
    // Radix beyond sixteen, the top of the field, and a radix of one.
    rows.push_back(write_row(sird_pkg::REG_RADIX_LENGTH, 64'd17));
    rows.push_back(value_row(5, 1'b1, ""));
    rows.push_back(write_row(sird_pkg::REG_RADIX_LENGTH, '1));
    rows.push_back(value_row(-7, 1'b1, ""));
    rows.push_back(write_row(sird_pkg::REG_RADIX_LENGTH, 64'd1));
    rows.push_back(value_row(5, 1'b1, ""));
    // Sign characters and a repeated character.
    rows.push_back(alphabet_row("0+"));
    rows.push_back(value_row(3, 1'b1, ""));
    rows.push_back(alphabet_row("-1"));
    rows.push_back(value_row(3, 1'b1, ""));
    rows.push_back(alphabet_row("abca"));
    rows.push_back(value_row(3, 1'b1, ""));
    // A zero byte as digit zero. The write to the unmapped index must change nothing.
    rows.push_back(write_row(sird_pkg::REG_RADIX_LENGTH, 64'd2));
    rows.push_back(write_row(sird_pkg::REG_ALPHABET_LOW, 64'h0000_0000_0000_3100));
    rows.push_back(write_row(REG_UNMAPPED, '1));
    rows.push_back(value_row(0, 1'b0, ""));
    rows.push_back(value_row(-6, 1'b0, ""));

    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_VALUE: send_number(rows[i].number, rows[i].typed, rows[i].text);
        ROW_WRITE: write_register(rows[i].index, rows[i].data);
        default: begin
          word = '0;
          for (int k = 0; k < rows[i].text.len(); k++) word[8*k +: 8] = rows[i].text[k];
          write_register(sird_pkg::REG_RADIX_LENGTH, 64'(rows[i].text.len()));
          write_register(sird_pkg::REG_ALPHABET_LOW, word[63:0]);
          write_register(sird_pkg::REG_ALPHABET_HIGH, word[127:64]);
        end
      endcase
    end
  endtask

  // Program a random alphabet. Mostly valid; otherwise break it in one of three ways.
  task automatic new_alphabet(input bit force_valid);
    alpha_flavour_t                 flavour;
    int                             roll;
    int                             len;
    int                             a;
    int                             b;
    logic [7:0]                     c;
    bit [255:0]                     used;
    logic [2*sird_pkg::ALPHA_W-1:0] word;
    logic [sird_pkg::ALPHA_W-1:0]   len_word;
    roll = $urandom_range(0, 9);
    flavour = force_valid || roll < 6 ? ALPHA_GOOD :
              roll < 7 ? ALPHA_BAD_LENGTH : roll < 8 ? ALPHA_SIGN : ALPHA_REPEAT;
    roll = $urandom_range(0, 3);
    len = roll == 0 ? 2 : roll == 1 ? 16 : $urandom_range(2, 16);
    if (flavour == ALPHA_BAD_LENGTH)
      len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
    used = '0;
    for (int k = 0; k < 16; k++) begin
      do c = 8'($urandom_range(0, 255));
      while (c == sird_pkg::CH_PLUS || c == sird_pkg::CH_MINUS || used[c]);
      used[c] = 1'b1;
      word[8*k +: 8] = c;
    end
    if (flavour == ALPHA_SIGN) begin
      a = $urandom_range(0, len - 1);
      word[8*a +: 8] = $urandom_range(0, 1) ? sird_pkg::CH_PLUS : sird_pkg::CH_MINUS;
    end
    if (flavour == ALPHA_REPEAT) begin
      a = $urandom_range(0, len - 2);
      b = $urandom_range(a + 1, len - 1);
      word[8*b +: 8] = word[8*a +: 8];
    end
    // Fill the bits above the length field with random noise.
    len_word      = {$urandom, $urandom};
    len_word[4:0] = 5'(len);
    write_register(sird_pkg::REG_RADIX_LENGTH, len_word);
    write_register(sird_pkg::REG_ALPHABET_LOW, word[63:0]);
    write_register(sird_pkg::REG_ALPHABET_HIGH, word[127:64]);
    if ($urandom_range(0, 3) == 0) write_register(REG_UNMAPPED, {$urandom, $urandom});
  endtask

  function automatic logic signed [31:0] random_number();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        roll = $urandom_range(0, 4);
        return roll == 0 ? 32'sh8000_0000 : roll == 1 ? 32'sh7FFF_FFFF :
               roll == 2 ? 32'sd0 : roll == 3 ? -32'sd1 : 32'sd1;
      end
      1, 2: return $signed($urandom_range(0, 600)) - 300;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic run_random();
    int counted;
    int phase;
    int phase_items;
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_VALUES) begin
      new_alphabet(phase == 1 || phase % 5 == 4);
      phase_items = $urandom_range(10, 30);
      steady_mode = (phase % 4 == 3);
      // Stall the sink long enough that the block backs up and refuses input.
      if (phase == 1) sink_hold_req = 1'b1;
      for (int i = 0; i < phase_items && counted < RANDOM_VALUES; i++) begin
        send_number(random_number(), 1'b0, "");
        counted++;
        if (phase % 5 == 4 && i == phase_items / 2) drain_results();
      end
      phase++;
    end
    steady_mode = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    drain_results();
    repeat (IDLE_GAP) @(posedge clk);
    if (error_count == 0) begin
      $display("[signed_integer_to_radix_digits] OK");
    end else begin
      $display("[signed_integer_to_radix_digits] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Drive tready: mostly high, with short drops, rare long ones,
  // and one long hold-off on request.
  initial begin
    int roll;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        out_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (steady_mode) begin
        out_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_tready <= 1'b1;
        end else if (roll < 97) begin
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character 0x%02h (tlast %0b)", out_tdata, out_tlast);
        error_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_tdata !== head_char.character) begin
          $error("character: expected 0x%02h, got 0x%02h", head_char.character, out_tdata);
          error_count++;
        end
        if (out_tlast !== head_char.final_char) begin
          $error("final_char: expected %0b, got %0b", head_char.final_char, out_tlast);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #40ms;
    $display("[signed_integer_to_radix_digits] ERROR");
    $finish;
  end

endmodule
